>>> rtl/core/tcw_pkg.sv
// shared constants, command codes and inter-module structs for the text console writer
// no dependencies; imported by the top level, tcw_front and tcw_back
package tcw_pkg;

    localparam int COLUMNS = 80;
    localparam int ROWS    = 25;
    localparam int CELLS   = ROWS * COLUMNS;
    localparam int ADDR_W  = $clog2(CELLS);

    localparam int ROW_W   = 5;
    localparam int COL_W   = 7;
    localparam int CHAR_W  = 8;
    localparam int CELL_W  = 16;
    localparam int CMD_W   = 2;

    localparam int S_DATA_W = 24;
    localparam int M_DATA_W = 32;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'd10;
    localparam logic [CHAR_W-1:0] SPACE_CODE   = 8'd32;
    localparam logic [7:0]        ATTR_RESET   = 8'd15;

    // input command codes
    localparam logic [CMD_W-1:0] CMD_PRINT = 2'd0;
    localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd1;
    localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;

    // classified operation kinds
    localparam logic [2:0] KIND_PRINT   = 3'd0;
    localparam logic [2:0] KIND_NEWLINE = 3'd1;
    localparam logic [2:0] KIND_CLEAR   = 3'd2;
    localparam logic [2:0] KIND_READ    = 3'd3;
    localparam logic [2:0] KIND_NOP     = 3'd4;

    typedef struct packed {
        logic [2:0]        kind;
        logic [CHAR_W-1:0] char_code;
        logic [ROW_W-1:0]  read_row;
        logic [COL_W-1:0]  read_col;
    } op_entry_t;

    typedef struct packed {
        logic      valid;
        op_entry_t entry;
    } queue_head_t;

    typedef struct packed {
        logic pop;
        logic init_busy;
    } back_status_t;

    // logical row/column to store address, rows rotated by the top-row offset
    function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] row,
                                                    input logic [COL_W-1:0] col,
                                                    input logic [ROW_W-1:0] top);
        logic [ROW_W:0] sum;
        logic [ROW_W:0] prow;
        sum  = {1'b0, row} + {1'b0, top};
        prow = (sum >= (ROW_W+1)'(ROWS)) ? sum - (ROW_W+1)'(ROWS) : sum;
        return ADDR_W'(int'(prow) * COLUMNS + int'(col));
    endfunction

endpackage

>>> rtl/core/text_console_writer.sv
// text console writer top level: stream in, stream out, apb attribute register
// path: beat queued in tcw_front, then result register in tcw_back; a read adds the ram read
// throughput: 1 item per cycle while m_tready is high and no read, scroll or clear is busy;
// a scroll blanks one row (COLUMNS cells), a clear all ROWS*COLUMNS cells of the screen ram
// reset: synchronous active low; afterwards a pass zeroes the screen ram while s_tready
// stays low; cursor homes and the attribute returns to 0x0f
module text_console_writer (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // char_code[7:0], read_row[12:8], read_col[19:13]
    input  logic [1:0]  s_tuser,   // cmd[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // cell_value[15:0], cursor_row[20:16], cursor_col[27:21]
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    import tcw_pkg::*;

    logic [7:0]   attr_reg;
    logic [7:0]   attr_next;
    logic         attr_hit;
    queue_head_t  head;
    back_status_t status;

    assign pready   = 1'b1;
    assign attr_hit = !paddr[2];

    always_comb begin
        attr_next = attr_reg;
        if (psel && penable && pwrite && pready && attr_hit) begin
            attr_next = pwdata[7:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            attr_reg <= ATTR_RESET;
        end else begin
            attr_reg <= attr_next;
        end
    end

    assign prdata = attr_hit ? {24'd0, attr_reg} : 32'd0;

    tcw_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .status   (status),
        .head     (head)
    );

    tcw_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .head     (head),
        .status   (status),
        .attr     (attr_reg),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

>>> rtl/core/tcw_ram.sv
// generic single write port, single read port ram with registered read data
// no dependencies
module tcw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

>>> rtl/core/tcw_front.sv
// front end: accepts input beats, classifies them and holds them in a short queue
// depends on tcw_pkg
module tcw_front (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [tcw_pkg::S_DATA_W-1:0]       s_tdata,
    input  logic [tcw_pkg::CMD_W-1:0]          s_tuser,
    input  tcw_pkg::back_status_t              status,
    output tcw_pkg::queue_head_t               head
);

    import tcw_pkg::*;

    op_entry_t         entries [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QPTR_W:0]   count_reg, count_next;
    op_entry_t         class_entry;
    logic              push;

    logic [CHAR_W-1:0] in_char;
    logic [ROW_W-1:0]  in_row;
    logic [COL_W-1:0]  in_col;

    assign in_char = s_tdata[CHAR_W-1:0];
    assign in_row  = s_tdata[CHAR_W+ROW_W-1:CHAR_W];
    assign in_col  = s_tdata[CHAR_W+ROW_W+COL_W-1:CHAR_W+ROW_W];

    assign s_tready = (count_reg != (QPTR_W+1)'(QUEUE_DEPTH)) && !status.init_busy;
    assign push     = s_tvalid && s_tready;

    always_comb begin
        class_entry.char_code = in_char;
        class_entry.read_row  = in_row;
        class_entry.read_col  = in_col;
        case (s_tuser)
            CMD_PRINT: begin
                class_entry.kind = (in_char == NEWLINE_CODE) ? KIND_NEWLINE : KIND_PRINT;
            end
            CMD_CLEAR: begin
                class_entry.kind = KIND_CLEAR;
            end
            CMD_READ: begin
                // out-of-range reads answer zero without touching the store
                if (in_row < ROW_W'(ROWS) && in_col < COL_W'(COLUMNS)) begin
                    class_entry.kind = KIND_READ;
                end else begin
                    class_entry.kind = KIND_NOP;
                end
            end
            default: begin
                class_entry.kind = KIND_NOP;
            end
        endcase
    end

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH-1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (status.pop) begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH-1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !status.pop) begin
            count_next = count_reg + 1'b1;
        end else if (!push && status.pop) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entries[wr_ptr_reg] <= class_entry;
        end
    end

    assign head.valid = (count_reg != '0);
    assign head.entry = entries[rd_ptr_reg];

endmodule

>>> rtl/core/tcw_back.sv
// back end: cursor, row rotation, screen store sweeps and the result register
// depends on tcw_pkg and tcw_ram
module tcw_back (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  tcw_pkg::queue_head_t         head,
    output tcw_pkg::back_status_t        status,
    input  logic [7:0]                   attr,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [tcw_pkg::M_DATA_W-1:0] m_tdata
);

    import tcw_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_READ = 2'd1;
    localparam logic [1:0] ST_FILL = 2'd2;

    logic [1:0]        state_reg, state_next;
    logic              init_reg, init_next;
    logic [ADDR_W-1:0] fill_addr_reg, fill_addr_next;
    logic [ADDR_W-1:0] fill_end_reg, fill_end_next;
    logic [ROW_W-1:0]  cur_row_reg, cur_row_next;
    logic [COL_W-1:0]  cur_col_reg, cur_col_next;
    logic [ROW_W-1:0]  top_reg, top_next;
    logic [ADDR_W-1:0] top_base_reg, top_base_next;

    logic              out_valid_reg, out_valid_next;
    logic [CELL_W-1:0] out_cell_reg, out_cell_next;
    logic [ROW_W-1:0]  out_row_reg, out_row_next;
    logic [COL_W-1:0]  out_col_reg, out_col_next;

    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [CELL_W-1:0] ram_wdata;
    logic              ram_re;
    logic [ADDR_W-1:0] ram_raddr;
    logic [CELL_W-1:0] ram_rdata;

    logic              out_free;
    logic              pop;
    logic              next_line;

    tcw_ram #(
        .WIDTH (CELL_W),
        .DEPTH (CELLS)
    ) u_screen (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign out_free = !out_valid_reg || m_tready;

    always_comb begin
        state_next     = state_reg;
        init_next      = init_reg;
        fill_addr_next = fill_addr_reg;
        fill_end_next  = fill_end_reg;
        cur_row_next   = cur_row_reg;
        cur_col_next   = cur_col_reg;
        top_next       = top_reg;
        top_base_next  = top_base_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_cell_next  = out_cell_reg;
        out_row_next   = out_row_reg;
        out_col_next   = out_col_reg;
        ram_we         = 1'b0;
        ram_waddr      = fill_addr_reg;
        ram_wdata      = init_reg ? '0 : {attr, SPACE_CODE};
        ram_re         = 1'b0;
        ram_raddr      = cell_addr(head.entry.read_row, head.entry.read_col, top_reg);
        pop            = 1'b0;
        next_line      = 1'b0;

        case (state_reg)
            ST_FILL: begin
                ram_we = 1'b1;
                if (fill_addr_reg == fill_end_reg) begin
                    state_next = ST_IDLE;
                    init_next  = 1'b0;
                end else begin
                    fill_addr_next = fill_addr_reg + 1'b1;
                end
            end
            ST_READ: begin
                // output slot is free here: nothing else loads it while a read is out
                out_valid_next = 1'b1;
                out_cell_next  = ram_rdata;
                state_next     = ST_IDLE;
            end
            ST_IDLE: begin
                if (head.valid && out_free) begin
                    pop            = 1'b1;
                    out_valid_next = 1'b1;
                    out_cell_next  = '0;
                    case (head.entry.kind)
                        KIND_PRINT: begin
                            ram_we    = 1'b1;
                            ram_waddr = cell_addr(cur_row_reg, cur_col_reg, top_reg);
                            ram_wdata = {attr, head.entry.char_code};
                            if (cur_col_reg == COL_W'(COLUMNS-1)) begin
                                next_line = 1'b1;
                            end else begin
                                cur_col_next = cur_col_reg + 1'b1;
                            end
                        end
                        KIND_NEWLINE: begin
                            next_line = 1'b1;
                        end
                        KIND_CLEAR: begin
                            cur_row_next   = '0;
                            cur_col_next   = '0;
                            top_next       = '0;
                            top_base_next  = '0;
                            fill_addr_next = '0;
                            fill_end_next  = ADDR_W'(CELLS-1);
                            state_next     = ST_FILL;
                        end
                        KIND_READ: begin
                            ram_re         = 1'b1;
                            out_valid_next = 1'b0;
                            state_next     = ST_READ;
                        end
                        default: begin
                        end
                    endcase

                    if (next_line) begin
                        cur_col_next = '0;
                        if (cur_row_reg == ROW_W'(ROWS-1)) begin
                            // scroll: old top row becomes the blank bottom row
                            fill_addr_next = top_base_reg;
                            fill_end_next  = top_base_reg + ADDR_W'(COLUMNS-1);
                            state_next     = ST_FILL;
                            if (top_reg == ROW_W'(ROWS-1)) begin
                                top_next      = '0;
                                top_base_next = '0;
                            end else begin
                                top_next      = top_reg + 1'b1;
                                top_base_next = top_base_reg + ADDR_W'(COLUMNS);
                            end
                        end else begin
                            cur_row_next = cur_row_reg + 1'b1;
                        end
                    end

                    out_row_next = cur_row_next;
                    out_col_next = cur_col_next;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_FILL;
            init_reg      <= 1'b1;
            fill_addr_reg <= '0;
            fill_end_reg  <= ADDR_W'(CELLS-1);
            cur_row_reg   <= '0;
            cur_col_reg   <= '0;
            top_reg       <= '0;
            top_base_reg  <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            init_reg      <= init_next;
            fill_addr_reg <= fill_addr_next;
            fill_end_reg  <= fill_end_next;
            cur_row_reg   <= cur_row_next;
            cur_col_reg   <= cur_col_next;
            top_reg       <= top_next;
            top_base_reg  <= top_base_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_cell_reg <= out_cell_next;
        out_row_reg  <= out_row_next;
        out_col_reg  <= out_col_next;
    end

    assign status.pop       = pop;
    assign status.init_busy = init_reg;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = M_DATA_W'({out_col_reg, out_row_reg, out_cell_reg});

endmodule
